FILE: hw/rtl/variable_record_ring_queue_assert.svh
// Assertion macros used by the checker file of the record ring queue.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef VARIABLE_RECORD_RING_QUEUE_ASSERT_SVH
`define VARIABLE_RECORD_RING_QUEUE_ASSERT_SVH

// clocked check, switched off while reset is held
`define VRRQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define VRRQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/vrrq_pkg.sv
// Types and codes of the variable record ring queue.
// Used by the controller, the datapath, the top level and the checker.
package vrrq_pkg;

	localparam int LEN_W  = 12;
	localparam int TAG_W  = 48;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		OP_PUSH_BEGIN = 2'd0,
		OP_PUSH_BYTE  = 2'd1,
		OP_PULL_BEGIN = 2'd2,
		OP_PULL_BYTE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_SEQUENCE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_HDR_WR,
		S_HDR_RD,
		S_HDR_FIN,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic    latch;
		logic    push_start;
		logic    push_byte;
		logic    pull_start;
		logic    pull_byte;
		logic    hdr_wr;
		logic    hdr_rd;
		logic    hdr_fin;
		logic    reject;
		logic    load_out;
		status_t code;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic too_long;
		logic full;
		logic empty;
		logic push_open;
		logic pull_open;
		logic hdr_done;
	} flags_t;

endpackage

FILE: hw/rtl/vrrq_ctrl.sv
// Sequencing state machine of the record ring queue.
// Depends on vrrq_pkg; drives the datapath through cmd_t, reads flags_t.
module vrrq_ctrl import vrrq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_ready,
	output logic   rsp_valid,
	input  logic   rsp_ready,
	input  flags_t flags,
	output cmd_t   cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				case (flags.op)
					OP_PUSH_BEGIN: state_d = (flags.too_long || flags.full) ? S_RESULT : S_HDR_WR;
					OP_PULL_BEGIN: state_d = flags.empty ? S_RESULT : S_HDR_RD;
					default:       state_d = S_RESULT;
				endcase
			end
			S_HDR_WR: begin
				if (flags.hdr_done) state_d = S_RESULT;
			end
			S_HDR_RD: begin
				if (flags.hdr_done) state_d = S_HDR_FIN;
			end
			S_HDR_FIN: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) state_d = req_valid ? S_DECIDE : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.code  = ST_OK;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			S_DECIDE: begin
				case (flags.op)
					OP_PUSH_BEGIN: begin
						if (flags.too_long) begin
							cmd.reject = 1'b1;
							cmd.code   = ST_TOO_LONG;
						end else if (flags.full) begin
							cmd.reject = 1'b1;
							cmd.code   = ST_FULL;
						end else begin
							cmd.push_start = 1'b1;
						end
					end
					OP_PUSH_BYTE: begin
						if (!flags.push_open) begin
							cmd.reject = 1'b1;
							cmd.code   = ST_SEQUENCE;
						end else begin
							cmd.push_byte = 1'b1;
						end
					end
					OP_PULL_BEGIN: begin
						if (flags.empty) begin
							cmd.reject = 1'b1;
							cmd.code   = ST_EMPTY;
						end else begin
							cmd.pull_start = 1'b1;
						end
					end
					OP_PULL_BYTE: begin
						if (!flags.pull_open) begin
							cmd.reject = 1'b1;
							cmd.code   = ST_SEQUENCE;
						end else begin
							cmd.pull_byte = 1'b1;
						end
					end
					default: begin
						cmd.reject = 1'b1;
						cmd.code   = ST_SEQUENCE;
					end
				endcase
			end
			S_HDR_WR: begin
				cmd.hdr_wr = 1'b1;
			end
			S_HDR_RD: begin
				cmd.hdr_rd = 1'b1;
			end
			S_HDR_FIN: begin
				cmd.hdr_fin = 1'b1;
			end
			S_RESULT: begin
				// result register loads and the next word may come in together
				cmd.load_out = slot_free;
				req_ready    = slot_free;
				cmd.latch    = slot_free && req_valid;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/vrrq_dp.sv
// Datapath of the record ring queue: byte ring memory, positions, counters,
// header packing and the result register. Depends on vrrq_pkg.
module vrrq_dp import vrrq_pkg::*; #(
	parameter int RING_BYTES   = 4096,
	parameter int HEADER_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        operation,
	input  logic [LEN_W-1:0]  record_length,
	input  logic [TAG_W-1:0]  record_tag,
	input  logic [BYTE_W-1:0] payload_in,
	input  cmd_t              cmd,
	output flags_t            flags,
	output logic [2:0]        status,
	output logic [LEN_W-1:0]  length_out,
	output logic [TAG_W-1:0]  tag_out,
	output logic [BYTE_W-1:0] payload_out,
	output logic              last_byte
);

	localparam int PW        = $clog2(RING_BYTES);
	localparam int HW        = (HEADER_BYTES > 2) ? $clog2(HEADER_BYTES) : 1;
	localparam int CW        = (PW + 1 > LEN_W + 2) ? PW + 1 : LEN_W + 2;
	localparam int TAG_BYTES = HEADER_BYTES - 2;

	logic [BYTE_W-1:0] ring_mem [RING_BYTES];

	// latched word
	op_t               op_q;
	logic [LEN_W-1:0]  len_q;
	logic [TAG_W-1:0]  tag_q;
	logic [BYTE_W-1:0] byte_q;

	logic [PW-1:0]     wr_q, rd_q, fill_q, drain_q;
	logic [LEN_W-1:0]  fill_rem_q, drain_rem_q;
	logic              push_open_q, pull_open_q;
	logic [HW-1:0]     hcnt_q;

	// header read back
	logic [LEN_W-1:0]  hlen_q;
	logic [TAG_W-1:0]  htag_q;
	logic [BYTE_W-1:0] rd_data_q;

	// pending result
	status_t           pst_q;
	logic              plast_q, show_hdr_q, show_byte_q;

	logic [PW:0]       room;
	logic [CW-1:0]     need;
	logic              hdr_done;
	logic [BYTE_W-1:0] hdr_byte;
	logic              mem_we, mem_re;
	logic [PW-1:0]     mem_ra;
	logic [BYTE_W-1:0] mem_wd;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] a);
		return (a == PW'(RING_BYTES - 1)) ? '0 : a + 1'b1;
	endfunction

	// free space runs from the committed write position up to the read position
	always_comb begin
		if (wr_q >= rd_q) begin
			room = (PW+1)'(RING_BYTES) - {1'b0, wr_q} + {1'b0, rd_q};
		end else begin
			room = {1'b0, rd_q} - {1'b0, wr_q};
		end
		need = CW'(len_q) + CW'(HEADER_BYTES + 1);
	end

	assign hdr_done = (hcnt_q == HW'(HEADER_BYTES - 1));

	assign flags.op        = op_q;
	assign flags.too_long  = need > CW'(RING_BYTES);
	assign flags.full      = CW'(room) < need;
	assign flags.empty     = (wr_q == rd_q);
	assign flags.push_open = push_open_q;
	assign flags.pull_open = pull_open_q;
	assign flags.hdr_done  = hdr_done;

	// header byte order: length low, length high nibble, tag bytes low first
	always_comb begin
		hdr_byte = '0;
		if (hcnt_q == HW'(0)) begin
			hdr_byte = len_q[7:0];
		end else if (hcnt_q == HW'(1)) begin
			hdr_byte = {4'b0000, len_q[11:8]};
		end else begin
			for (int b = 0; b < TAG_BYTES; b++) begin
				if (int'(hcnt_q) == b + 2) hdr_byte = tag_q[8*b +: 8];
			end
		end
	end

	assign mem_we = cmd.hdr_wr || cmd.push_byte;
	assign mem_wd = cmd.hdr_wr ? hdr_byte : byte_q;
	assign mem_re = cmd.pull_start || cmd.pull_byte || (cmd.hdr_rd && !hdr_done);
	assign mem_ra = cmd.pull_start ? rd_q : drain_q;

	always_ff @(posedge clk) begin
		if (mem_we) ring_mem[fill_q] <= mem_wd;
		if (mem_re) rd_data_q <= ring_mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op_t'(operation);
			len_q  <= record_length;
			tag_q  <= record_tag;
			byte_q <= payload_in;
		end
		if (cmd.pull_start) begin
			htag_q <= '0;
		end else if (cmd.hdr_rd) begin
			if (hcnt_q == HW'(0)) begin
				hlen_q[7:0] <= rd_data_q;
			end else if (hcnt_q == HW'(1)) begin
				hlen_q[11:8] <= rd_data_q[3:0];
			end else begin
				for (int b = 0; b < TAG_BYTES; b++) begin
					if (int'(hcnt_q) == b + 2) htag_q[8*b +: 8] <= rd_data_q;
				end
			end
		end
		if (cmd.reject) begin
			pst_q       <= cmd.code;
			plast_q     <= 1'b0;
			show_hdr_q  <= 1'b0;
			show_byte_q <= 1'b0;
		end else if (cmd.push_start) begin
			pst_q       <= ST_OK;
			plast_q     <= 1'b0;
			show_hdr_q  <= 1'b0;
			show_byte_q <= 1'b0;
		end else if (cmd.push_byte) begin
			pst_q       <= ST_OK;
			plast_q     <= (fill_rem_q == LEN_W'(1));
			show_hdr_q  <= 1'b0;
			show_byte_q <= 1'b0;
		end else if (cmd.pull_start) begin
			pst_q       <= ST_OK;
			plast_q     <= 1'b0;
			show_hdr_q  <= 1'b1;
			show_byte_q <= 1'b0;
		end else if (cmd.pull_byte) begin
			pst_q       <= ST_OK;
			plast_q     <= (drain_rem_q == LEN_W'(1));
			show_hdr_q  <= 1'b0;
			show_byte_q <= 1'b1;
		end
		if (cmd.load_out) begin
			status      <= pst_q;
			length_out  <= show_hdr_q ? hlen_q : '0;
			tag_out     <= show_hdr_q ? htag_q : '0;
			payload_out <= show_byte_q ? rd_data_q : '0;
			last_byte   <= plast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			fill_q      <= '0;
			drain_q     <= '0;
			fill_rem_q  <= '0;
			drain_rem_q <= '0;
			push_open_q <= 1'b0;
			pull_open_q <= 1'b0;
			hcnt_q      <= '0;
		end else begin
			if (cmd.reject) begin
				if (op_q == OP_PUSH_BEGIN) push_open_q <= 1'b0;
				if (op_q == OP_PULL_BEGIN) pull_open_q <= 1'b0;
			end
			if (cmd.push_start) begin
				fill_q      <= wr_q;
				fill_rem_q  <= len_q;
				hcnt_q      <= '0;
				push_open_q <= 1'b0;
			end
			if (cmd.hdr_wr) begin
				fill_q <= nxt(fill_q);
				hcnt_q <= hcnt_q + 1'b1;
				if (hdr_done) begin
					// a record with no payload is committed with its header
					if (len_q == '0) begin
						wr_q <= nxt(fill_q);
					end else begin
						push_open_q <= 1'b1;
					end
				end
			end
			if (cmd.push_byte) begin
				fill_q     <= nxt(fill_q);
				fill_rem_q <= fill_rem_q - 1'b1;
				if (fill_rem_q == LEN_W'(1)) begin
					wr_q        <= nxt(fill_q);
					push_open_q <= 1'b0;
				end
			end
			if (cmd.pull_start) begin
				drain_q     <= nxt(rd_q);
				hcnt_q      <= '0;
				pull_open_q <= 1'b0;
			end
			if (cmd.hdr_rd && !hdr_done) begin
				drain_q <= nxt(drain_q);
				hcnt_q  <= hcnt_q + 1'b1;
			end
			if (cmd.hdr_fin) begin
				if (hlen_q == '0) begin
					rd_q <= drain_q;
				end else begin
					drain_rem_q <= hlen_q;
					pull_open_q <= 1'b1;
				end
			end
			if (cmd.pull_byte) begin
				drain_q     <= nxt(drain_q);
				drain_rem_q <= drain_rem_q - 1'b1;
				if (drain_rem_q == LEN_W'(1)) begin
					rd_q        <= nxt(drain_q);
					pull_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/variable_record_ring_queue.sv
// Variable record ring queue: records of a fixed header (length and tag) plus
// payload live in a byte ring of RING_BYTES single-port memory entries. One
// word is worked on at a time; a result register lets the next word enter in
// the cycle the previous result is loaded. A push or pull payload byte, and
// every rejected word, is decided (and its byte moved through the memory
// port), then its result is loaded. Push begin writes the header through the
// one memory port a byte per cycle; pull begin reads it the same way and adds
// a finishing state (S_HDR_FIN) for registered read data. No clearing pass
// follows reset.
module variable_record_ring_queue import vrrq_pkg::*; #(
	parameter int RING_BYTES   = 4096,
	parameter int HEADER_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        operation,
	input  logic [LEN_W-1:0]  record_length,
	input  logic [TAG_W-1:0]  record_tag,
	input  logic [BYTE_W-1:0] payload_in,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [2:0]        status,
	output logic [LEN_W-1:0]  length_out,
	output logic [TAG_W-1:0]  tag_out,
	output logic [BYTE_W-1:0] payload_out,
	output logic              last_byte
);

	cmd_t   cmd;
	flags_t flags;

	vrrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	vrrq_dp #(
		.RING_BYTES   (RING_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (operation),
		.record_length (record_length),
		.record_tag    (record_tag),
		.payload_in    (payload_in),
		.cmd           (cmd),
		.flags         (flags),
		.status        (status),
		.length_out    (length_out),
		.tag_out       (tag_out),
		.payload_out   (payload_out),
		.last_byte     (last_byte)
	);

endmodule

FILE: hw/rtl/vrrq_checker.sv
// Port-level checks of the record ring queue, bound to the top level.
// Depends on vrrq_pkg and variable_record_ring_queue_assert.svh.
`include "variable_record_ring_queue_assert.svh"

module vrrq_checker import vrrq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [1:0]        operation,
	input logic [LEN_W-1:0]  record_length,
	input logic [TAG_W-1:0]  record_tag,
	input logic [BYTE_W-1:0] payload_in,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [2:0]        status,
	input logic [LEN_W-1:0]  length_out,
	input logic [TAG_W-1:0]  tag_out,
	input logic [BYTE_W-1:0] payload_out,
	input logic              last_byte
);

	// result word holds until taken
	`VRRQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status), "result word dropped before taken")

	// one word at a time: the cycle after an accept is always busy
	`VRRQ_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "second word taken while busy")

	// errors carry no byte and no end mark
	`VRRQ_ASSERT(a_err_clean, rsp_valid && status != ST_OK |-> !last_byte && payload_out == '0 && length_out == '0, "error result carries data")

	// a header result never ends a record
	`VRRQ_ASSERT(a_hdr_not_last, rsp_valid && length_out != '0 |-> status == ST_OK && !last_byte, "header result marked last")

endmodule

bind variable_record_ring_queue vrrq_checker u_vrrq_checker (.*);

FILE: tb/variable_record_ring_queue_tb.sv
// Testbench for the variable record ring queue: directed corner words, then long random
// push and pull sequences checked against a byte-ring predictor held in a small scoreboard.
// Depends on vrrq_pkg and the variable_record_ring_queue top level.
module variable_record_ring_queue_tb;
	import vrrq_pkg::*;

	localparam int RING_SIZE = 4096;
	localparam int HDR_BYTES = 8;

	typedef struct {
		status_t           status;
		logic [LEN_W-1:0]  len;
		logic [TAG_W-1:0]  tag;
		logic [BYTE_W-1:0] data;
		logic              last;
	} word_result_t;

	class ring_ledger;
		logic [7:0]   ring [RING_SIZE];
		int           wr_pos, rd_pos, fill_at, fill_left, drain_at, drain_left;
		bit           push_open, pull_open;
		int           write_wraps, errors, checked;
		int           status_tally [8];
		word_result_t awaited [$];

		function int free_bytes();
			return (wr_pos >= rd_pos) ? RING_SIZE - wr_pos + rd_pos : rd_pos - wr_pos;
		endfunction

		function void put_byte(logic [7:0] value);
			ring[fill_at] = value;
			fill_at = (fill_at + 1 >= RING_SIZE) ? 0 : fill_at + 1;
		endfunction

		function logic [7:0] take_byte();
			logic [7:0] value;
			value = ring[drain_at];
			drain_at = (drain_at + 1 >= RING_SIZE) ? 0 : drain_at + 1;
			return value;
		endfunction

		function void commit_write();
			if (fill_at < wr_pos)
				write_wraps++;
			wr_pos = fill_at;
		endfunction

		// predicts the result of one accepted word and queues it
		function void accept_word(op_t op, logic [LEN_W-1:0] len, logic [TAG_W-1:0] tag,
				logic [BYTE_W-1:0] data);
			word_result_t r;
			int need, k;
			logic [7:0] lo, hi;
			logic [TAG_W-1:0] got_tag;
			r.status = ST_OK;
			r.len = '0;
			r.tag = '0;
			r.data = '0;
			r.last = 1'b0;
			case (op)
				OP_PUSH_BEGIN: begin
					push_open = 1'b0;
					need = HDR_BYTES + int'(len) + 1;
					if (need > RING_SIZE) begin
						r.status = ST_TOO_LONG;
					end else if (free_bytes() < need) begin
						r.status = ST_FULL;
					end else begin
						fill_at = wr_pos;
						put_byte(len[7:0]);
						put_byte({4'h0, len[11:8]});
						for (k = 0; k < HDR_BYTES - 2; k++)
							put_byte(tag[8*k +: 8]);
						if (len == '0) begin
							commit_write();
							fill_left = 0;
						end else begin
							fill_left = int'(len);
							push_open = 1'b1;
						end
					end
				end
				OP_PUSH_BYTE: begin
					if (!push_open || fill_left == 0) begin
						push_open = 1'b0;
						r.status = ST_SEQUENCE;
					end else begin
						put_byte(data);
						fill_left--;
						if (fill_left == 0) begin
							commit_write();
							push_open = 1'b0;
							r.last = 1'b1;
						end
					end
				end
				OP_PULL_BEGIN: begin
					pull_open = 1'b0;
					if (wr_pos == rd_pos) begin
						r.status = ST_EMPTY;
					end else begin
						drain_at = rd_pos;
						lo = take_byte();
						hi = take_byte();
						got_tag = '0;
						for (k = 0; k < HDR_BYTES - 2; k++)
							got_tag[8*k +: 8] = take_byte();
						r.len = {hi[3:0], lo};
						r.tag = got_tag;
						if (r.len == '0) begin
							rd_pos = drain_at;
							drain_left = 0;
						end else begin
							drain_left = int'(r.len);
							pull_open = 1'b1;
						end
					end
				end
				default: begin
					if (!pull_open || drain_left == 0) begin
						pull_open = 1'b0;
						r.status = ST_SEQUENCE;
					end else begin
						r.data = take_byte();
						drain_left--;
						if (drain_left == 0) begin
							rd_pos = drain_at;
							pull_open = 1'b0;
							r.last = 1'b1;
						end
					end
				end
			endcase
			status_tally[r.status]++;
			awaited.insert(awaited.size(), r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= 40)
				$display("result %0d %s: got %0h, want %0h", checked, what, got, want);
		endtask

		task check_result(logic [2:0] st, logic [LEN_W-1:0] len, logic [TAG_W-1:0] tag,
				logic [BYTE_W-1:0] data, logic last);
			word_result_t want;
			if (awaited.size() == 0) begin
				report("arrived with nothing outstanding", 64'(st), 64'd0);
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			checked++;
			if (st !== want.status)
				report("status", 64'(st), 64'(want.status));
			if (len !== want.len)
				report("length", 64'(len), 64'(want.len));
			if (tag !== want.tag)
				report("tag", 64'(tag), 64'(want.tag));
			if (data !== want.data)
				report("payload", 64'(data), 64'(want.data));
			if (last !== want.last)
				report("last mark", 64'(last), 64'(want.last));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [1:0]        operation = OP_PULL_BEGIN;
	logic [LEN_W-1:0]  record_length = '0;
	logic [TAG_W-1:0]  record_tag = '0;
	logic [BYTE_W-1:0] payload_in = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [2:0]        status;
	logic [LEN_W-1:0]  length_out;
	logic [TAG_W-1:0]  tag_out;
	logic [BYTE_W-1:0] payload_out;
	logic              last_byte;

	ring_ledger ledger;
	int  words_sent = 0;
	bit  send_idling = 1'b1;
	bit  rsp_idling = 1'b1;
	bit  squeeze_req = 1'b0;
	bit  squeeze_done = 1'b0;
	int  stall_left = 0;

	variable_record_ring_queue #(
		.RING_BYTES(RING_SIZE),
		.HEADER_BYTES(HDR_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.record_length(record_length),
		.record_tag(record_tag),
		.payload_in(payload_in),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.length_out(length_out),
		.tag_out(tag_out),
		.payload_out(payload_out),
		.last_byte(last_byte)
	);

	always #5 clk = ~clk;

	// result side: check at the edge, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			ledger.check_result(status, length_out, tag_out, payload_out, last_byte);
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (squeeze_req && !squeeze_done) begin
			// long hold so the result path backs up into the input
			squeeze_done = 1'b1;
			stall_left = 399;
			rsp_ready <= 1'b0;
		end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 12);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic logic [TAG_W-1:0] rand_tag();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TAG_W-1:0];
	endfunction

	task automatic send_word(op_t op, logic [LEN_W-1:0] len, logic [TAG_W-1:0] tag,
			logic [BYTE_W-1:0] data);
		int gap;
		if (send_idling && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		record_length <= len;
		record_tag <= tag;
		payload_in <= data;
		do @(posedge clk); while (!req_ready);
		ledger.accept_word(op, len, tag, data);
		words_sent++;
	endtask

	task automatic random_transaction(int txn);
		int pick, push_share, r, keep, n, fit_len;
		logic [LEN_W-1:0] len;
		// alternate fill-heavy and drain-heavy stretches
		push_share = ((txn / 150) % 2 == 0) ? 55 : 30;
		pick = $urandom_range(0, 99);
		if (pick < push_share) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				len = '0;
			end else if (r < 84) begin
				len = LEN_W'($urandom_range(1, 8));
			end else if (r < 93) begin
				len = LEN_W'($urandom_range(9, 48));
			end else if (r < 95) begin
				len = LEN_W'($urandom_range(49, 300));
			end else if (r < 98) begin
				// straddle the exact-fit boundary of the free space
				fit_len = ledger.free_bytes() - HDR_BYTES - 2 + int'($urandom_range(0, 2));
				if (fit_len > 4095)
					fit_len = 4095;
				if (fit_len < 0)
					fit_len = 0;
				len = LEN_W'(fit_len);
			end else begin
				len = LEN_W'($urandom_range(1000, 4095));
			end
			if (len > 300)
				keep = $urandom_range(0, 3);
			else if ($urandom_range(0, 19) == 0)
				keep = $urandom_range(0, int'(len));
			else
				keep = int'(len);
			send_word(OP_PUSH_BEGIN, len, rand_tag(), BYTE_W'($urandom_range(0, 255)));
			n = 0;
			while (ledger.push_open && n < keep) begin
				send_word(OP_PUSH_BYTE, LEN_W'($urandom_range(0, 4095)), rand_tag(),
					BYTE_W'($urandom_range(0, 255)));
				n++;
			end
		end else if (pick < 85) begin
			keep = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : RING_SIZE;
			send_word(OP_PULL_BEGIN, LEN_W'($urandom_range(0, 4095)), rand_tag(),
				BYTE_W'($urandom_range(0, 255)));
			n = 0;
			while (ledger.pull_open && n < keep) begin
				send_word(OP_PULL_BYTE, LEN_W'($urandom_range(0, 4095)), rand_tag(),
					BYTE_W'($urandom_range(0, 255)));
				n++;
			end
		end else begin
			send_word(op_t'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 4095)),
				rand_tag(), BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		#10_000_000;
		$display("timed out with %0d results outstanding", ledger.awaited.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int txn, tail_start;
		ledger = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring and stray payload words
		send_word(OP_PULL_BEGIN, 12'h000, 48'h0, 8'h00);
		send_word(OP_PULL_BYTE, 12'hFFF, 48'hFFFF_FFFF_FFFF, 8'hFF);
		send_word(OP_PUSH_BYTE, 12'h000, 48'h0, 8'hA5);
		// too long, then an exact fit on an empty ring
		send_word(OP_PUSH_BEGIN, 12'hFFF, 48'hFFFF_FFFF_FFFF, 8'h00);
		send_word(OP_PUSH_BEGIN, 12'd4088, 48'h1234_5678_9ABC, 8'h00);
		send_word(OP_PUSH_BEGIN, 12'd4087, 48'hA5A5_5A5A_C3C3, 8'h00);
		send_word(OP_PUSH_BYTE, 12'h000, 48'h0, 8'hFF);
		// zero-length record abandons the open one and commits at once
		send_word(OP_PUSH_BEGIN, 12'h000, 48'hFFFF_FFFF_FFFF, 8'h00);
		send_word(OP_PUSH_BEGIN, 12'd4087, 48'h0, 8'h00);
		send_word(OP_PUSH_BEGIN, 12'd4079, 48'h0F0F_F0F0_0F0F, 8'h00);
		send_word(OP_PUSH_BEGIN, 12'd2, 48'h0, 8'h00);
		send_word(OP_PUSH_BYTE, 12'h000, 48'h0, 8'h00);
		send_word(OP_PUSH_BYTE, 12'hFFF, 48'hFFFF_FFFF_FFFF, 8'hFF);
		send_word(OP_PUSH_BYTE, 12'h000, 48'h0, 8'h5A);
		send_word(OP_PULL_BEGIN, 12'h000, 48'h0, 8'h00);
		send_word(OP_PULL_BEGIN, 12'h000, 48'h0, 8'h00);
		send_word(OP_PULL_BYTE, 12'h000, 48'h0, 8'h00);
		// restart of an open pull
		send_word(OP_PULL_BEGIN, 12'h000, 48'h0, 8'h00);
		send_word(OP_PULL_BYTE, 12'h000, 48'h0, 8'h00);
		send_word(OP_PULL_BYTE, 12'h000, 48'h0, 8'h00);
		send_word(OP_PULL_BYTE, 12'h000, 48'h0, 8'h00);
		send_word(OP_PULL_BEGIN, 12'h000, 48'h0, 8'h00);

		// header-only records walk both positions once round the ring end
		while (ledger.write_wraps == 0) begin
			send_word(OP_PUSH_BEGIN, 12'h000, rand_tag(), 8'h00);
			send_word(OP_PULL_BEGIN, 12'h000, 48'h0, 8'h00);
		end

		txn = 0;
		while ((words_sent < 1300 || ledger.write_wraps == 0) && words_sent < 6000) begin
			if (txn % 150 == 0) begin
				send_idling = ($urandom_range(0, 3) != 0);
				rsp_idling = ($urandom_range(0, 3) != 0);
			end
			if (words_sent >= 500)
				squeeze_req = 1'b1;
			random_transaction(txn);
			txn++;
		end
		// closing stretch at full rate on both sides
		send_idling = 1'b0;
		rsp_idling = 1'b0;
		tail_start = words_sent;
		while (words_sent < tail_start + 200) begin
			random_transaction(txn);
			txn++;
		end
		req_valid <= 1'b0;

		while (ledger.awaited.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("%0d words sent, %0d results checked, write position wrapped %0d times",
			words_sent, ledger.checked, ledger.write_wraps);
		$display("ok %0d, full %0d, too long %0d, empty %0d, out of sequence %0d",
			ledger.status_tally[ST_OK], ledger.status_tally[ST_FULL],
			ledger.status_tally[ST_TOO_LONG], ledger.status_tally[ST_EMPTY],
			ledger.status_tally[ST_SEQUENCE]);
		if (ledger.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
